### sv/bssc_pkg.sv
// ----------------------------------------------------------------------------
// bssc_pkg
// Shared types, opcodes and sizes for the bit-set list store.
// ----------------------------------------------------------------------------
package bssc_pkg;

   localparam int SET_BITS = 64;
   localparam int MAX_SETS = 16;

   localparam int SET_W   = 64;
   localparam int OP_W    = 3;
   localparam int OUT_CNT_W = 5;

   localparam int ADDR_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int CNT_W  = $clog2(MAX_SETS + 1);

   localparam logic [SET_W-1:0] ELEM_MASK =
      (SET_BITS >= SET_W) ? {SET_W{1'b1}} : ((SET_W'(1) << SET_BITS) - SET_W'(1));

   localparam logic [OP_W-1:0] OP_FLUSH          = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH           = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND_EQUAL     = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND_SUPER     = 3'd3;
   localparam logic [OP_W-1:0] OP_PUSH_UNCOVERED = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [SET_W-1:0] query_set;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic                 full_error;
      logic [OUT_CNT_W-1:0] set_count;
   } rsp_type;

endpackage

### sv/bssc_ram.sv
// ----------------------------------------------------------------------------
// bssc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bssc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bitset_list_subset_store_unit.sv
// ----------------------------------------------------------------------------
// bitset_list_subset_store_unit
// List of bit sets with push, flush, equal search, covering-set search and push of uncovered sets.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | bssc_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_stall | bssc_pkg::rsp_type
//
// Flush, push and unused opcodes, and searches of an empty list, answer without
// a scan; searches read the stored sets from the RAM one at a time and stop
// early on the first hit.
// Reset clears the count; the set RAM needs no clearing.
// One item at a time; a held result stalls the next item only until taken.
// ----------------------------------------------------------------------------
module bitset_list_subset_store_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bssc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bssc_pkg::rsp_type rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                           state_ff, state_in;
   logic [bssc_pkg::ADDR_W-1:0]    cur_ff, cur_in;
   logic [bssc_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [bssc_pkg::OP_W-1:0]      op_ff;
   logic [bssc_pkg::SET_W-1:0]     query_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   bssc_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           req_accept;
   logic                           rsp_free;
   logic                           produce;
   logic                           found;
   logic                           full_err;
   logic                           is_full;
   logic                           hit;
   logic                           last;
   logic [bssc_pkg::SET_W-1:0]     q_masked;

   logic                           mem_we;
   logic [bssc_pkg::ADDR_W-1:0]    mem_waddr;
   logic [bssc_pkg::SET_W-1:0]     mem_wdata;
   logic                           mem_re;
   logic [bssc_pkg::ADDR_W-1:0]    mem_raddr;
   logic [bssc_pkg::SET_W-1:0]     mem_rdata;

   bssc_ram #(
      .WIDTH (bssc_pkg::SET_W),
      .DEPTH (bssc_pkg::MAX_SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign q_masked   = req_data.query_set & bssc_pkg::ELEM_MASK;
   assign is_full    = (count_ff == bssc_pkg::CNT_W'(bssc_pkg::MAX_SETS));
   assign last       = ((bssc_pkg::CNT_W'(cur_ff) + bssc_pkg::CNT_W'(1)) == count_ff);
   assign hit        = (op_ff == bssc_pkg::OP_FIND_EQUAL) ? (mem_rdata == query_ff) :
                       ((mem_rdata & query_ff) == query_ff);

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      produce   = 1'b0;
      found     = 1'b0;
      full_err  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = bssc_pkg::ADDR_W'(count_ff);
      mem_wdata = (state_ff == ST_SCAN) ? query_ff : q_masked;
      mem_re    = 1'b0;
      mem_raddr = '0;

      if (state_ff == ST_IDLE) begin
         if (req_accept) begin
            produce = 1'b1;
            unique case (req_data.opcode) inside
               bssc_pkg::OP_FLUSH: begin
                  count_in = '0;
               end
               bssc_pkg::OP_PUSH: begin
                  if (is_full) begin
                     full_err = 1'b1;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + bssc_pkg::CNT_W'(1);
                  end
               end
               bssc_pkg::OP_FIND_EQUAL, bssc_pkg::OP_FIND_SUPER,
               bssc_pkg::OP_PUSH_UNCOVERED: begin
                  if (count_ff == '0) begin
                     if (req_data.opcode == bssc_pkg::OP_PUSH_UNCOVERED) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + bssc_pkg::CNT_W'(1);
                     end
                  end else begin
                     produce   = 1'b0;
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     cur_in    = '0;
                     state_in  = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
      end else begin
         if (hit) begin
            produce  = 1'b1;
            found    = 1'b1;
            state_in = ST_IDLE;
         end else if (last) begin
            produce  = 1'b1;
            state_in = ST_IDLE;
            if (op_ff == bssc_pkg::OP_PUSH_UNCOVERED) begin
               if (is_full) begin
                  full_err = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + bssc_pkg::CNT_W'(1);
               end
            end
         end else begin
            mem_re    = 1'b1;
            mem_raddr = cur_ff + bssc_pkg::ADDR_W'(1);
            cur_in    = cur_ff + bssc_pkg::ADDR_W'(1);
         end
      end

      rsp_in.found      = found;
      rsp_in.full_error = full_err;
      rsp_in.set_count  = bssc_pkg::OUT_CNT_W'(count_in);
      rsp_valid_in      = produce || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_data.opcode;
         query_ff <= q_masked;
      end
      if (produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bssc_pkg::CNT_W'(bssc_pkg::MAX_SETS))
      else $error("stored count exceeds capacity");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("result pending during a scan");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (bssc_pkg::CNT_W'(cur_ff) < count_ff))
      else $error("scan beyond stored sets");

   a_write_at_tail: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (count_ff == $past(count_ff) + bssc_pkg::CNT_W'(1)))
      else $error("write did not advance count");

   a_scan_ends_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (state_in == ST_IDLE)) |=> rsp_valid_ff)
      else $error("scan ended without a result");
`endif

endmodule
